>>> rtl/core/epoch_seconds_to_date_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the epoch seconds to date block
// Both macros sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_DATE_TOP_ASSERT_SVH
`define EPOCH_SECONDS_TO_DATE_TOP_ASSERT_SVH

// same-cycle implication
`define ESTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/estd_pkg.sv
// ---------------------------------------------------------------------------
// estd_pkg
// Shared types, constants and calendar functions for the date converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package estd_pkg;

  localparam int SEC_W   = 32;
  localparam int EPOCH_W = 12;
  localparam int YEAR_W  = 13;  // epoch year plus the years walked
  localparam int DAYZ_W  = 9;   // zero-based day count, up to 366
  localparam int STEP_W  = 4;

  localparam logic [EPOCH_W-1:0] EPOCH_RESET = 12'd2020;
  localparam logic [YEAR_W-1:0]  YEAR_BASE   = 13'd1900;
  localparam logic [EPOCH_W-1:0] MOD25       = 12'd25;
  localparam logic [4:0]         MOD25_LAST  = 5'd24;

  localparam logic [SEC_W-1:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [SEC_W-1:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [SEC_W-1:0] SECS_PER_MIN  = 32'd60;
  localparam logic [SEC_W-1:0] SECS_YEAR     = 32'd31536000;  // 365 days
  localparam logic [SEC_W-1:0] SECS_LEAP     = 32'd31622400;  // 366 days

  // reciprocals for the constant divisions, rounded up; exact over the
  // operand ranges used (epoch year, day seconds after >> 7, >> 4, >> 2)
  localparam logic [12:0] MOD25_RECIP = 13'd5243;    // 2^17 / 25
  localparam logic [18:0] DAY_RECIP   = 19'd397683;  // 2^28 / 675
  localparam logic [12:0] HOUR_RECIP  = 13'd4661;    // 2^20 / 225
  localparam logic [10:0] MIN_RECIP   = 11'd1093;    // 2^14 / 15

  // each division: a quotient step, then a remainder step
  localparam logic [STEP_W-1:0] MOD_STEP_TOP  = 4'd0;
  localparam logic [STEP_W-1:0] DAY_STEP_TOP  = 4'd1;
  localparam logic [STEP_W-1:0] HOUR_STEP_TOP = 4'd1;
  localparam logic [STEP_W-1:0] MIN_STEP_TOP  = 4'd1;

  localparam logic [3:0] MON_LAST = 4'd11;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MOD,
    OP_YEAR,
    OP_DIV,
    OP_MONTH
  } op_t;

  typedef enum logic [1:0] {
    DSEL_DAY,
    DSEL_HOUR,
    DSEL_MIN
  } dsel_t;

  typedef struct packed {
    op_t               op;
    dsel_t             dsel;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic year_gt;   // remaining seconds exceed the current year length
    logic month_ge;  // zero-based day is past the current month
  } stat_t;

  // year mod 4 == 0, and not (mod 25 == 0 unless mod 16 == 0)
  function automatic logic is_leap(input logic [YEAR_W-1:0] year, input logic [4:0] ymod25);
    is_leap = (year[1:0] == 2'b00) && ((ymod25 != 5'd0) || (year[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    case (mon)
      4'd0:    month_days = 5'd31;
      4'd1:    month_days = leap ? 5'd29 : 5'd28;
      4'd2:    month_days = 5'd31;
      4'd3:    month_days = 5'd30;
      4'd4:    month_days = 5'd31;
      4'd5:    month_days = 5'd30;
      4'd6:    month_days = 5'd31;
      4'd7:    month_days = 5'd31;
      4'd8:    month_days = 5'd30;
      4'd9:    month_days = 5'd31;
      4'd10:   month_days = 5'd30;
      4'd11:   month_days = 5'd31;
      default: month_days = 5'd31;
    endcase
  endfunction

endpackage

>>> rtl/core/estd_datapath.sv
// ---------------------------------------------------------------------------
// estd_datapath
// Epoch register, year walk subtractor, reciprocal-multiply constant
// dividers and month walk; all but the epoch register follow controller commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "epoch_seconds_to_date_top_assert.svh"

module estd_datapath import estd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [EPOCH_W-1:0] cfg_wdata,
  input  logic [SEC_W-1:0]   in_seconds_since_epoch,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic [5:0]         out_second,
  output logic [5:0]         out_minute,
  output logic [4:0]         out_hour,
  output logic [4:0]         out_day_of_month,
  output logic [3:0]         out_month,
  output logic [8:0]         out_year_since_1900
);

  logic [EPOCH_W-1:0] epoch_r;
  logic [SEC_W-1:0]   rem_r;
  logic [YEAR_W-1:0]  year_r;
  logic [EPOCH_W-1:0] ymod_r;   // year mod 25 once reduced
  logic [7:0]         q25_r;    // epoch year / 25
  logic [DAYZ_W-1:0]  dayz_r;
  logic [4:0]         hour_r;
  logic [5:0]         min_r;
  logic [3:0]         mon_r;

  logic               leap;
  logic [SEC_W-1:0]   ysecs;
  logic [4:0]         mlen;
  logic [24:0]        mod_prod;
  logic [EPOCH_W-1:0] mod_sub;
  logic [EPOCH_W-1:0] mod_diff;
  logic [36:0]        day_prod;
  logic [24:0]        hour_prod;
  logic [19:0]        min_prod;
  logic [SEC_W-1:0]   div_sub;
  logic [4:0]         ymod_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= EPOCH_RESET;
    end else if (cfg_we) begin
      epoch_r <= cfg_wdata;
    end
  end

  assign leap      = is_leap(year_r, ymod_r[4:0]);
  assign ysecs     = leap ? SECS_LEAP : SECS_YEAR;
  assign mlen      = month_days(mon_r, leap);
  assign ymod_inc  = (ymod_r[4:0] == MOD25_LAST) ? 5'd0 : ymod_r[4:0] + 5'd1;

  // quotients by reciprocal; the remaining seconds are below 2^25 once the
  // year walk is done, below 86400 after the day step, below 3600 after hours
  assign mod_prod  = {13'd0, epoch_r} * {12'd0, MOD25_RECIP};
  assign mod_sub   = {4'd0, q25_r} * MOD25;
  assign mod_diff  = year_r[EPOCH_W-1:0] - mod_sub;
  assign day_prod  = {19'd0, rem_r[24:7]} * {18'd0, DAY_RECIP};
  assign hour_prod = {12'd0, rem_r[16:4]} * {12'd0, HOUR_RECIP};
  assign min_prod  = {10'd0, rem_r[11:2]} * {9'd0, MIN_RECIP};

  always_comb begin
    case (cmd.dsel)
      DSEL_DAY:  div_sub = {23'd0, dayz_r} * SECS_PER_DAY;
      DSEL_HOUR: div_sub = {27'd0, hour_r} * SECS_PER_HOUR;
      DSEL_MIN:  div_sub = {26'd0, min_r} * SECS_PER_MIN;
      default:   div_sub = {26'd0, min_r} * SECS_PER_MIN;
    endcase
  end

  assign stat.year_gt  = rem_r > ysecs;
  assign stat.month_ge = dayz_r >= {4'd0, mlen};

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        rem_r  <= in_seconds_since_epoch;
        year_r <= {1'b0, epoch_r};
        q25_r  <= mod_prod[24:17];
        dayz_r <= '0;
        hour_r <= '0;
        min_r  <= '0;
        mon_r  <= '0;
      end
      OP_MOD: begin
        ymod_r <= mod_diff;
      end
      OP_YEAR: begin
        if (stat.year_gt) begin
          rem_r  <= rem_r - ysecs;
          year_r <= year_r + 13'd1;
          ymod_r <= {7'd0, ymod_inc};
        end
      end
      OP_DIV: begin
        if (cmd.step != '0) begin
          case (cmd.dsel)
            DSEL_DAY:  dayz_r <= day_prod[36:28];
            DSEL_HOUR: hour_r <= hour_prod[24:20];
            DSEL_MIN:  min_r  <= min_prod[19:14];
            default:   min_r  <= min_prod[19:14];
          endcase
        end else begin
          rem_r <= rem_r - div_sub;
        end
      end
      OP_MONTH: begin
        if (stat.month_ge) begin
          dayz_r <= dayz_r - {4'd0, mlen};
          if (mon_r == MON_LAST) begin
            mon_r  <= '0;
            year_r <= year_r + 13'd1;
            ymod_r <= {7'd0, ymod_inc};
          end else begin
            mon_r <= mon_r + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_second          = rem_r[5:0];
  assign out_minute          = min_r;
  assign out_hour            = hour_r;
  assign out_day_of_month    = dayz_r[4:0] + 5'd1;
  assign out_month           = mon_r;
  assign out_year_since_1900 = 9'(year_r - YEAR_BASE);

  // the year walk must start from a fully reduced residue
  `ESTD_ASSERT_NOW(a_ymod_reduced, cmd.op == OP_YEAR, ymod_r < MOD25, "year residue not reduced")
  `ESTD_ASSERT_NOW(a_day_walk_fits, cmd.op == OP_MONTH, dayz_r <= 9'd366, "day count out of range")
  `ESTD_ASSERT_NEXT(a_month_wrap, cmd.op == OP_MONTH && stat.month_ge && mon_r == MON_LAST,
                    mon_r == 4'd0, "month did not wrap to January")

endmodule

>>> rtl/core/estd_ctrl.sv
// ---------------------------------------------------------------------------
// estd_ctrl
// Sequencer for the conversion: residue reduction, year walk, three
// constant divisions and month walk; issues one datapath command a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "epoch_seconds_to_date_top_assert.svh"

module estd_ctrl import estd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  out_valid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_YEAR,
    ST_DIVD,
    ST_DIVH,
    ST_DIVM,
    ST_MONTH
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              out_valid_r;
  logic              accept;

  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_MOD;
            step_r  <= MOD_STEP_TOP;
            busy_r  <= 1'b1;
          end
        end
        ST_MOD: begin
          if (step_r == '0) begin
            state_r <= ST_YEAR;
          end else begin
            step_r <= step_r - 4'd1;
          end
        end
        ST_YEAR: begin
          if (!stat.year_gt) begin
            state_r <= ST_DIVD;
            step_r  <= DAY_STEP_TOP;
          end
        end
        ST_DIVD: begin
          if (step_r == '0) begin
            state_r <= ST_DIVH;
            step_r  <= HOUR_STEP_TOP;
          end else begin
            step_r <= step_r - 4'd1;
          end
        end
        ST_DIVH: begin
          if (step_r == '0) begin
            state_r <= ST_DIVM;
            step_r  <= MIN_STEP_TOP;
          end else begin
            step_r <= step_r - 4'd1;
          end
        end
        ST_DIVM: begin
          if (step_r == '0) begin
            state_r <= ST_MONTH;
          end else begin
            step_r <= step_r - 4'd1;
          end
        end
        ST_MONTH: begin
          if (!stat.month_ge) begin
            state_r     <= ST_IDLE;
            busy_r      <= 1'b0;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.step = step_r;
    cmd.dsel = DSEL_DAY;
    case (state_r)
      ST_IDLE:  cmd.op = accept ? OP_LOAD : OP_NONE;
      ST_MOD:   cmd.op = OP_MOD;
      ST_YEAR:  cmd.op = OP_YEAR;
      ST_DIVD:  cmd.op = OP_DIV;
      ST_DIVH: begin
        cmd.op   = OP_DIV;
        cmd.dsel = DSEL_HOUR;
      end
      ST_DIVM: begin
        cmd.op   = OP_DIV;
        cmd.dsel = DSEL_MIN;
      end
      ST_MONTH: cmd.op = OP_MONTH;
      default:  cmd.op = OP_NONE;
    endcase
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  `ESTD_ASSERT_NOW(a_busy_tracks_state, 1'b1, busy_r == (state_r != ST_IDLE), "busy out of step")
  `ESTD_ASSERT_NOW(a_done_idle, out_valid_r, !busy_r, "result strobe while busy")
  `ESTD_ASSERT_NEXT(a_single_strobe, out_valid_r, !out_valid_r, "result strobe too long")
  `ESTD_ASSERT_NEXT(a_year_exit, state_r == ST_YEAR && !stat.year_gt,
                    state_r == ST_DIVD && step_r == DAY_STEP_TOP, "bad exit from year walk")

endmodule

>>> rtl/core/epoch_seconds_to_date_top.sv
// ---------------------------------------------------------------------------
// epoch_seconds_to_date_top
// Converts seconds since January 1 of a configurable epoch year into a
// Gregorian broken-down date.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The result
// appears with a single-cycle out_valid strobe after these steps in order:
// a mod-25 reduction of the epoch year; the year walk, which removes the
// whole years (0..136) one year per cycle through the single 32-bit compare
// and subtract; a day, an hour and a minute division, each a reciprocal
// multiply, then a multiply and subtract; and the month walk (0..12 months).
// The receiver cannot stall: the strobe lasts exactly one cycle and must be
// taken then. The out_ fields stay valid until the next transaction is
// accepted. The epoch_year register (reset 2020) may be written through
// cfg_we/cfg_wdata only while busy is low.
`timescale 1ns / 1ps

module epoch_seconds_to_date_top import estd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [EPOCH_W-1:0] cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic [SEC_W-1:0]   in_seconds_since_epoch,
  output logic               out_valid,
  output logic [5:0]         out_second,
  output logic [5:0]         out_minute,
  output logic [4:0]         out_hour,
  output logic [4:0]         out_day_of_month,
  output logic [3:0]         out_month,
  output logic [8:0]         out_year_since_1900
);

  cmd_t  cmd;
  stat_t stat;

  estd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  estd_datapath u_datapath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .in_seconds_since_epoch (in_seconds_since_epoch),
    .cmd                    (cmd),
    .stat                   (stat),
    .out_second             (out_second),
    .out_minute             (out_minute),
    .out_hour               (out_hour),
    .out_day_of_month       (out_day_of_month),
    .out_month              (out_month),
    .out_year_since_1900    (out_year_since_1900)
  );

endmodule

>>> tb/tb_epoch_seconds_to_date_top.sv
// ---------------------------------------------------------------------------
// tb_epoch_seconds_to_date_top
// Self-checking bench for the epoch seconds to date converter. A local
// calendar model predicts the date of every accepted transaction. The
// results are checked field by field, in order, across several epoch years
// and under different patterns of gaps between start requests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_epoch_seconds_to_date_top;
  import estd_pkg::*;

  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 200;
  localparam int unsigned SECS_DAY     = 86400;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [8:0] year_since_1900;
  } date_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [EPOCH_W-1:0] cfg_wdata = '0;
  logic               start     = 1'b0;
  logic [SEC_W-1:0]   in_seconds_since_epoch = '0;
  logic               busy;
  logic               out_valid;
  logic [5:0]         out_second;
  logic [5:0]         out_minute;
  logic [4:0]         out_hour;
  logic [4:0]         out_day_of_month;
  logic [3:0]         out_month;
  logic [8:0]         out_year_since_1900;

  date_t              pending_dates[$];
  date_t              want_date;
  logic [EPOCH_W-1:0] epoch_model = EPOCH_RESET;
  int                 err_count   = 0;
  int                 n_sent      = 0;
  int                 n_checked   = 0;
  int                 n_epochs    = 1;
  int                 cycle_count = 0;

  epoch_seconds_to_date_top u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .start                  (start),
    .busy                   (busy),
    .in_seconds_since_epoch (in_seconds_since_epoch),
    .out_valid              (out_valid),
    .out_second             (out_second),
    .out_minute             (out_minute),
    .out_hour               (out_hour),
    .out_day_of_month       (out_day_of_month),
    .out_month              (out_month),
    .out_year_since_1900    (out_year_since_1900)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 25 != 0) || (y % 16 == 0));
  endfunction

  function automatic int unsigned year_len_secs(input int unsigned y);
    return leap_year(y) ? 366 * SECS_DAY : 365 * SECS_DAY;
  endfunction

  function automatic int unsigned month_len(input int unsigned mon, input int unsigned y);
    if (mon == 1) begin
      return 28 + int'(leap_year(y));
    end
    return 31 - ((mon % 7) & 1);
  endfunction

  function automatic date_t seconds_to_date(input logic [SEC_W-1:0] secs,
                                            input logic [EPOCH_W-1:0] epoch);
    int unsigned rem;
    int unsigned year;
    int unsigned ylen;
    int unsigned mday;
    int unsigned mon;
    int unsigned yoff;
    date_t d;
    rem  = secs;
    year = {20'd0, epoch};
    ylen = year_len_secs(year);
    // stops when rem equals a full year; the month walk carries that case
    while (rem > ylen) begin
      rem  -= ylen;
      year += 1;
      ylen  = year_len_secs(year);
    end
    d.second = 6'(rem % 60);
    rem      = rem / 60;
    d.minute = 6'(rem % 60);
    rem      = rem / 60;
    d.hour   = 5'(rem % 24);
    mday     = rem / 24 + 1;
    mon      = 0;
    while (mday > month_len(mon, year)) begin
      mday -= month_len(mon, year);
      mon  += 1;
      if (mon > 11) begin
        mon   = 0;
        year += 1;
      end
    end
    yoff              = year - 1900;  // wraps for epochs below 1900
    d.day_of_month    = 5'(mday);
    d.month           = 4'(mon);
    d.year_since_1900 = 9'(yoff);
    return d;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want_date = pending_dates.pop_front();
        n_checked++;
        if (out_second !== want_date.second)
          report_mismatch("second", int'(out_second), int'(want_date.second));
        if (out_minute !== want_date.minute)
          report_mismatch("minute", int'(out_minute), int'(want_date.minute));
        if (out_hour !== want_date.hour)
          report_mismatch("hour", int'(out_hour), int'(want_date.hour));
        if (out_day_of_month !== want_date.day_of_month)
          report_mismatch("day_of_month", int'(out_day_of_month),
                          int'(want_date.day_of_month));
        if (out_month !== want_date.month)
          report_mismatch("month", int'(out_month), int'(want_date.month));
        if (out_year_since_1900 !== want_date.year_since_1900)
          report_mismatch("year_since_1900", int'(out_year_since_1900),
                          int'(want_date.year_since_1900));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_dates.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving
  // start stays high when the next transaction follows with no gap
  task automatic send_seconds(input logic [SEC_W-1:0] secs, input int idle_pct);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap   = ($urandom_range(3) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start                  <= 1'b1;
    in_seconds_since_epoch <= secs;
    do @(posedge clk); while (busy);
    pending_dates.push_back(seconds_to_date(secs, epoch_model));
    n_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_epoch(input logic [EPOCH_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    epoch_model  = value;
    n_epochs++;
  endtask

  // seconds near year starts and day edges reach the walks at their limits
  function automatic logic [SEC_W-1:0] pick_seconds(input logic [EPOCH_W-1:0] epoch);
    longint unsigned base;
    int unsigned     y;
    int              kind;
    int              k;
    kind = $urandom_range(3);
    if (kind == 0) begin
      return $urandom;
    end
    if (kind == 3) begin
      return $urandom_range(0, 1 << 24);
    end
    k    = $urandom_range(0, 140);
    base = 0;
    y    = {20'd0, epoch};
    repeat (k) begin
      base += 64'(year_len_secs(y));
      y++;
    end
    if (kind == 2) begin
      base += longint'($urandom_range(0, 365)) * SECS_DAY;
    end
    base += 64'($urandom_range(0, 2));
    if (base != 0) begin
      base -= 1;
    end
    if (base > 64'hFFFF_FFFF) begin
      return $urandom;
    end
    return base[SEC_W-1:0];
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_reset_epoch();
    logic [SEC_W-1:0] one_year;
    one_year = year_len_secs({20'd0, epoch_model});
    send_seconds(32'd0, 0);
    send_seconds(32'd59, 0);
    send_seconds(32'd3600, 0);
    send_seconds(32'd86399, 0);
    send_seconds(32'd59 * SECS_DAY, 0);   // Feb 29 of a leap epoch
    send_seconds(one_year, 0);            // exactly one year: next Jan 1
    send_seconds(one_year + 1, 0);
    send_seconds(32'hFFFF_FFFF, 0);
    send_seconds(32'hAAAA_AAAA, 0);
    send_seconds(32'h5555_5555, 0);
  endtask

  task automatic test_epoch_extremes();
    logic [EPOCH_W-1:0] epochs[5];
    epochs = '{12'd1970, 12'd2100, 12'd0, 12'hFFF, 12'd1899};
    foreach (epochs[i]) begin
      write_epoch(epochs[i]);
      send_seconds(32'd0, 0);
      send_seconds(32'hFFFF_FFFF, 0);
      send_seconds(year_len_secs({20'd0, epoch_model}), 0);
    end
  endtask

  task automatic test_random(input int idle_pct, input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 45 == 0) begin
        if ($urandom_range(9) < 7) write_epoch(EPOCH_W'($urandom_range(1970, 2100)));
        else write_epoch(EPOCH_W'($urandom_range(0, 4095)));
      end else if ($urandom_range(49) == 0) begin
        drain_results();
      end
      send_seconds(pick_seconds(epoch_model), idle_pct);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_epoch();
    test_epoch_extremes();
    test_random(32, 134);
    test_random(76, 133);
    test_random(0, 133);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d transactions, checked %0d results, %0d mismatches",
             n_sent, n_checked, err_count);
    $display("Covered %0d epoch year settings, year boundaries and full-range seconds",
             n_epochs);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
